// File: rtl/base64_stream_encoder_assert.svh
// ----------------------------------------------------------------------------
// Base64 stream encoder assertion macros
// Shared concurrent assertion forms for the encoder's checker.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B64E_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("base64 encoder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define B64E_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("base64 encoder: next-cycle check failed");

`endif

// File: rtl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// Base64 stream encoder package
// Beat types, queue entry type, constants and the alphabet lookup.
// ----------------------------------------------------------------------------
package b64e_pkg;

	localparam int unsigned JOB_CHARS   = 4;
	localparam int unsigned JOB_IDX_W   = $clog2(JOB_CHARS);
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	localparam logic [2:0] CNT_NONE = 3'd0;
	localparam logic [2:0] CNT_TWO  = 3'd2;
	localparam logic [2:0] CNT_FOUR = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} byte_beat_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       end_of_text;
	} char_beat_t;

	typedef struct packed {
		logic [JOB_CHARS-1:0][7:0] chars;
		logic [JOB_IDX_W-1:0]      last_idx;
		logic                      eot;
	} job_t;

	function automatic logic [7:0] b64_char(input logic [5:0] idx);
		logic [7:0] code;
		code = {2'b00, idx};
		if (idx < 6'd26) begin
			return code + 8'd65;
		end else if (idx < 6'd52) begin
			return code + 8'd71;
		end else if (idx < 6'd62) begin
			return code - 8'd4;
		end else if (idx == 6'd62) begin
			return 8'h2B;
		end else begin
			return 8'h2F;
		end
	endfunction

endpackage

// File: rtl/b64e_front.sv
// ----------------------------------------------------------------------------
// Base64 stream encoder front end
// Accepts message bytes, keeps the leftover bits and builds one character job.
// ----------------------------------------------------------------------------
module b64e_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  b64e_pkg::byte_beat_t byte_beat,
	output logic                push_valid,
	input  logic                push_ready,
	output b64e_pkg::job_t      push_job
);

	logic [3:0]  leftover_bits_q;
	logic [2:0]  leftover_count_q;
	logic [11:0] acc;
	logic [5:0]  idx0;
	logic [5:0]  idx1;
	logic [5:0]  tail_idx;
	logic        two_main;
	logic [2:0]  rem_cnt;
	logic [3:0]  rem_bits;
	logic        accept;

	assign byte_ready = push_ready;
	assign push_valid = byte_valid;
	assign accept     = byte_valid && push_ready;
	assign acc        = {leftover_bits_q, byte_beat.data_byte};

	always_comb begin
		idx0     = acc[11:6];
		idx1     = acc[5:0];
		tail_idx = 6'd0;
		two_main = 1'b1;
		rem_cnt  = b64e_pkg::CNT_NONE;
		rem_bits = 4'd0;
		case (leftover_count_q)
			b64e_pkg::CNT_NONE: begin
				idx0     = acc[7:2];
				tail_idx = {acc[1:0], 4'b0000};
				two_main = 1'b0;
				rem_cnt  = b64e_pkg::CNT_TWO;
				rem_bits = {2'b00, acc[1:0]};
			end
			b64e_pkg::CNT_TWO: begin
				idx0     = acc[9:4];
				tail_idx = {acc[3:0], 2'b00};
				two_main = 1'b0;
				rem_cnt  = b64e_pkg::CNT_FOUR;
				rem_bits = acc[3:0];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		push_job.chars[0] = b64e_pkg::b64_char(idx0);
		push_job.chars[1] = two_main ? b64e_pkg::b64_char(idx1) : b64e_pkg::b64_char(tail_idx);
		push_job.chars[2] = b64e_pkg::PAD_CHAR;
		push_job.chars[3] = b64e_pkg::PAD_CHAR;
		push_job.eot      = byte_beat.final_byte;
		if (!byte_beat.final_byte) begin
			push_job.last_idx = two_main ? b64e_pkg::JOB_IDX_W'(1) : b64e_pkg::JOB_IDX_W'(0);
		end else if (two_main) begin
			push_job.last_idx = b64e_pkg::JOB_IDX_W'(1);
		end else if (rem_cnt == b64e_pkg::CNT_TWO) begin
			push_job.last_idx = b64e_pkg::JOB_IDX_W'(3);
		end else begin
			push_job.last_idx = b64e_pkg::JOB_IDX_W'(2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leftover_bits_q  <= 4'd0;
			leftover_count_q <= b64e_pkg::CNT_NONE;
		end else if (accept) begin
			if (byte_beat.final_byte) begin
				leftover_bits_q  <= 4'd0;
				leftover_count_q <= b64e_pkg::CNT_NONE;
			end else begin
				leftover_bits_q  <= rem_bits;
				leftover_count_q <= rem_cnt;
			end
		end
	end

endmodule

// File: rtl/b64e_queue.sv
// ----------------------------------------------------------------------------
// Base64 stream encoder job queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module b64e_queue #(
	parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  b64e_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output b64e_pkg::job_t pop_job
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	b64e_pkg::job_t slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != CNT_W'(0));
	assign pop_job    = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/b64e_back.sv
// ----------------------------------------------------------------------------
// Base64 stream encoder back end
// Walks each queued job and sends one character per beat from a register.
// ----------------------------------------------------------------------------
module b64e_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  b64e_pkg::job_t       pop_job,
	output logic                 char_valid,
	input  logic                 char_ready,
	output b64e_pkg::char_beat_t char_beat
);

	logic                          out_valid_q;
	b64e_pkg::char_beat_t          out_q;
	logic [b64e_pkg::JOB_IDX_W-1:0] idx_q;
	logic                          load;
	logic                          at_last;

	assign load       = !out_valid_q || char_ready;
	assign at_last    = (idx_q == pop_job.last_idx);
	assign pop_ready  = load && at_last;
	assign char_valid = out_valid_q;
	assign char_beat  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= pop_valid;
			if (pop_valid) begin
				idx_q <= at_last ? '0 : idx_q + b64e_pkg::JOB_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && pop_valid) begin
			out_q.out_char    <= pop_job.chars[idx_q];
			out_q.end_of_text <= pop_job.eot && at_last;
		end
	end

endmodule

// File: rtl/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// Base64 stream encoder
// Encodes a byte stream into base64 characters with padding and an end mark.
// ----------------------------------------------------------------------------
// channel  | valid       | ready       | payload
// ---------+-------------+-------------+-------------------------------------
// bytes in | byte_valid  | byte_ready  | byte_beat (data_byte, final_byte)
// chars out| char_valid  | char_ready  | char_beat (out_char, end_of_text)
//
// A byte beat can be taken every cycle while the job queue has room.
// The back end sends one character per cycle while char_ready is high; a byte
// yields one or two characters, a final byte two to four; three bytes give four.
// The first character of a byte passes a queue slot and then the output register before it is offered.
// Reset clears the leftover bits, empties the queue and clears the output valid flag.
// A stalled char_ready holds the output; the queue then fills and drops byte_ready.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
	parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  b64e_pkg::byte_beat_t byte_beat,
	output logic                 char_valid,
	input  logic                 char_ready,
	output b64e_pkg::char_beat_t char_beat
);

	logic           push_valid;
	logic           push_ready;
	b64e_pkg::job_t push_job;
	logic           pop_valid;
	logic           pop_ready;
	b64e_pkg::job_t pop_job;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_beat  (byte_beat),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_beat  (char_beat)
	);

endmodule

// File: rtl/b64e_checker.sv
// ----------------------------------------------------------------------------
// Base64 stream encoder checker
// Port-level checks on character grouping, padding and stalls on both channels.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_assert.svh"

module b64e_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 byte_valid,
	input logic                 byte_ready,
	input b64e_pkg::byte_beat_t byte_beat,
	input logic                 char_valid,
	input logic                 char_ready,
	input b64e_pkg::char_beat_t char_beat
);

	logic [1:0] pos_q;
	logic       char_acc;
	logic       is_pad;

	assign char_acc = char_valid && char_ready;
	assign is_pad   = (char_beat.out_char == b64e_pkg::PAD_CHAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
		end else if (char_acc) begin
			pos_q <= char_beat.end_of_text ? 2'd0 : pos_q + 2'd1;
		end
	end

	`B64E_ASSERT_NEXT(a_byte_hold, clk, arst_n, byte_valid && !byte_ready, byte_valid && $stable(byte_beat))
	`B64E_ASSERT_NEXT(a_char_hold, clk, arst_n, char_valid && !char_ready, char_valid && $stable(char_beat))
	`B64E_ASSERT_SAME(a_end_group, clk, arst_n, char_acc && char_beat.end_of_text, pos_q == 2'd3)
	`B64E_ASSERT_SAME(a_pad_place, clk, arst_n, char_acc && is_pad, pos_q == 2'd2 || pos_q == 2'd3)
	`B64E_ASSERT_SAME(a_pad_end, clk, arst_n, char_acc && is_pad && pos_q == 2'd3, char_beat.end_of_text)

endmodule

bind base64_stream_encoder b64e_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (byte_valid),
	.byte_ready (byte_ready),
	.byte_beat  (byte_beat),
	.char_valid (char_valid),
	.char_ready (char_ready),
	.char_beat  (char_beat)
);
